[hw/rtl/mp1g_pkg.sv]
// shared types and constants for the 1-d max pool with gradient routing
package mp1g_pkg;

  // widths fixed by the item fields
  localparam int unsigned ValW   = 32;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned WidthW = 5;

  // largest pooling window honored, wider settings are clamped
  localparam int unsigned MaxWidth = 16;

  // depth of the queue between front and back
  localparam int unsigned QDepth = 4;

  // item function codes
  typedef enum logic {
    KindFwd = 1'b0,
    KindBwd = 1'b1
  } item_kind_e;

  // one command handed from front to back
  typedef struct packed {
    item_kind_e          kind;
    logic [ValW-1:0]     value;      // max (fwd) or gradient (bwd)
    logic [IdxW-1:0]     index;      // argmax (fwd) or window base (bwd)
    logic                last;
    logic                has_win;    // bwd: a window receives the gradient
    logic [IdxW-1:0]     pos;        // bwd: stored argmax of that window
    logic [WidthW-1:0]   width;      // effective window width
    logic [WidthW-1:0]   tail;       // bwd: zeros for the dropped tail
    logic [IdxW-1:0]     tail_base;  // bwd: first index of the tail
  } cmd_t;

endpackage

[hw/rtl/max_pool_1d_with_gradient_route.sv]
// Result path: front hand-off register, command queue, back end command and output registers.
// Throughput: one forward sample per cycle while the hand-off register or the queue has room;
//   a backward item holds the back end for its pool_width elements, plus the tail if last.
// The front keeps taking items while the four-entry command queue has room.
// Reset: control state clears and pool_width returns to 2; the argmax store is not cleared.
module max_pool_1d_with_gradient_route #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mp1g_pkg::WidthW-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             func_i,
  input  logic signed [mp1g_pkg::ValW-1:0] value_i,
  input  logic                             last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [mp1g_pkg::ValW-1:0] out_value_o,
  output logic [mp1g_pkg::IdxW-1:0]        out_index_o,
  output logic                             out_last_o
);

  logic           f_valid, f_ready, b_valid, b_ready;
  mp1g_pkg::cmd_t f_cmd, b_cmd;

  // item intake and pooling state
  mp1g_front #(
    .MaxLen(MAX_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .value_i    (value_i),
    .last_i     (last_i),
    .cmd_valid_o(f_valid),
    .cmd_ready_i(f_ready),
    .cmd_o      (f_cmd)
  );

  // command queue
  mp1g_fifo #(
    .Width($bits(mp1g_pkg::cmd_t)),
    .Depth(mp1g_pkg::QDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (f_valid),
    .in_ready_o (f_ready),
    .in_data_i  (f_cmd),
    .out_valid_o(b_valid),
    .out_ready_i(b_ready),
    .out_data_o (b_cmd)
  );

  // result sequencing
  mp1g_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(b_valid),
    .cmd_ready_o(b_ready),
    .cmd_i      (b_cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_value_o(out_value_o),
    .out_index_o(out_index_o),
    .out_last_o (out_last_o)
  );

endmodule

[hw/rtl/mp1g_ram.sv]
// generic single write, single read ram with registered read data
module mp1g_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/mp1g_fifo.sv]
// small flip-flop queue between front and back
module mp1g_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != Full);
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full)
    else $error("queue fill count beyond depth");
`endif

endmodule

[hw/rtl/mp1g_front.sv]
// front end: accepts items, tracks pooling state, keeps the argmax store
module mp1g_front #(
  parameter int unsigned MaxLen = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mp1g_pkg::WidthW-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            func_i,
  input  logic signed [mp1g_pkg::ValW-1:0] value_i,
  input  logic                            last_i,
  output logic                            cmd_valid_o,
  input  logic                            cmd_ready_i,
  output mp1g_pkg::cmd_t                  cmd_o
);

  localparam int unsigned PosW = $clog2(MaxLen + 1);
  localparam int unsigned AddrW = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam logic [PosW-1:0] MaxPos = PosW'(MaxLen);
  localparam logic [mp1g_pkg::WidthW-1:0] WMax = mp1g_pkg::WidthW'(mp1g_pkg::MaxWidth);

  // pooling state
  logic [mp1g_pkg::WidthW-1:0]      pw_q;
  logic signed [mp1g_pkg::ValW-1:0] max_q, max_d;
  logic [mp1g_pkg::IdxW-1:0]        best_q, best_d;
  logic [PosW-1:0]                  sp_q, sp_d;
  logic [mp1g_pkg::WidthW-1:0]      off_q, off_d;
  logic [PosW-1:0]                  wc_q, wc_d;
  logic [mp1g_pkg::WidthW-1:0]      tail_q, tail_d;
  logic [PosW-1:0]                  gw_q, gw_d;

  // hand-off register waiting for the store read
  logic           s1_v_q, s1_v_d;
  mp1g_pkg::cmd_t s1_q, cmd_d;
  logic           cmd_new;

  logic [mp1g_pkg::WidthW-1:0] w_eff;
  logic [PosW-1:0]             wc_base;
  logic [PosW-1:0]             gw_base;
  logic                        accept, fwd, in_range, closes, has_win;
  logic                        st_we, st_re;
  logic [mp1g_pkg::IdxW-1:0]   st_rdata;
  logic [mp1g_pkg::WidthW-1:0] off_inc;

  assign accept     = in_valid_i && in_ready_o;
  assign fwd        = (mp1g_pkg::item_kind_e'(func_i) == mp1g_pkg::KindFwd);
  assign in_ready_o = !s1_v_q || cmd_ready_i;

  // effective window width
  always_comb begin
    if (pw_q == '0) begin
      w_eff = mp1g_pkg::WidthW'(1);
    end else if (pw_q > WMax) begin
      w_eff = WMax;
    end else begin
      w_eff = pw_q;
    end
  end

  // a forward sample at position zero opens a new vector
  always_comb begin
    if (fwd && sp_q == '0 && off_q == '0) begin
      wc_base = '0;
      gw_base = '0;
    end else begin
      wc_base = wc_q;
      gw_base = gw_q;
    end
  end

  assign in_range = (sp_q < MaxPos);
  assign off_inc  = off_q + 1'b1;
  assign closes   = in_range && (off_inc >= w_eff);
  assign has_win  = (gw_q < wc_q);

  // state update and command build
  always_comb begin
    max_d   = max_q;
    best_d  = best_q;
    sp_d    = sp_q;
    off_d   = off_q;
    wc_d    = wc_base;
    tail_d  = tail_q;
    gw_d    = gw_base;
    cmd_new = 1'b0;
    cmd_d   = '0;
    cmd_d.value = value_i;
    cmd_d.last  = last_i;
    cmd_d.width = w_eff;
    if (fwd) begin
      cmd_d.kind = mp1g_pkg::KindFwd;
      if (in_range) begin
        if (off_q == '0 || value_i > max_q) begin
          max_d  = value_i;
          best_d = mp1g_pkg::IdxW'(sp_q);
        end
        off_d = off_inc;
        sp_d  = sp_q + 1'b1;
        if (closes) begin
          cmd_new = 1'b1;
          wc_d    = wc_base + 1'b1;
          off_d   = '0;
        end
      end
      cmd_d.value = max_d;
      cmd_d.index = best_d;
      if (last_i) begin
        tail_d = off_d;
        sp_d   = '0;
        off_d  = '0;
      end
    end else begin
      cmd_d.kind    = mp1g_pkg::KindBwd;
      cmd_d.has_win = has_win;
      cmd_d.index   = mp1g_pkg::IdxW'(gw_q) * mp1g_pkg::IdxW'(w_eff);
      cmd_d.tail_base = mp1g_pkg::IdxW'(wc_q) * mp1g_pkg::IdxW'(w_eff);
      if (has_win) begin
        gw_d = gw_q + 1'b1;
      end
      if (last_i) begin
        cmd_d.tail = tail_q;
        gw_d       = '0;
      end
      cmd_new = has_win || (last_i && tail_q != '0);
    end
  end

  assign st_we = accept && fwd && closes;
  assign st_re = accept && !fwd;

  // hand-off register control
  always_comb begin
    s1_v_d = s1_v_q;
    if (accept) begin
      s1_v_d = cmd_new;
    end else if (cmd_ready_i) begin
      s1_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q   <= mp1g_pkg::WidthW'(2);
      max_q  <= '0;
      best_q <= '0;
      sp_q   <= '0;
      off_q  <= '0;
      wc_q   <= '0;
      tail_q <= '0;
      gw_q   <= '0;
      s1_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pw_q <= cfg_wdata_i;
      end
      if (accept) begin
        max_q  <= max_d;
        best_q <= best_d;
        sp_q   <= sp_d;
        off_q  <= off_d;
        wc_q   <= wc_d;
        tail_q <= tail_d;
        gw_q   <= gw_d;
      end
      s1_v_q <= s1_v_d;
    end
  end

  // command payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= cmd_d;
    end
  end

  // argmax per window
  mp1g_ram #(
    .Width(mp1g_pkg::IdxW),
    .Depth(MaxLen)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(AddrW'(wc_base)),
    .wdata_i(best_d),
    .re_i   (st_re),
    .raddr_i(AddrW'(gw_q)),
    .rdata_o(st_rdata)
  );

  // the stored argmax joins the command on its way to the queue
  always_comb begin
    cmd_o = s1_q;
    if (s1_q.kind == mp1g_pkg::KindBwd && s1_q.has_win) begin
      cmd_o.pos = st_rdata;
    end
  end
  assign cmd_valid_o = s1_v_q;

`ifndef ASSERT_OFF
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !cmd_ready_i |-> !in_ready_o)
    else $error("item taken while hand-off register is stalled");
  a_gw_le_wc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gw_q <= wc_q)
    else $error("gradient window passed the window count");
  a_wc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wc_q <= MaxPos && sp_q <= MaxPos)
    else $error("window count or sample position beyond vector length");
`endif

endmodule

[hw/rtl/mp1g_back.sv]
// back end: turns queued commands into result transfers
module mp1g_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  output logic                             cmd_ready_o,
  input  mp1g_pkg::cmd_t                   cmd_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [mp1g_pkg::ValW-1:0] out_value_o,
  output logic [mp1g_pkg::IdxW-1:0]        out_index_o,
  output logic                             out_last_o
);

  typedef enum logic {
    PhWin,
    PhTail
  } phase_e;

  mp1g_pkg::cmd_t              cur_q, cur_d;
  logic                        cur_v_q, cur_v_d;
  phase_e                      ph_q, ph_d;
  logic [mp1g_pkg::WidthW-1:0] cnt_q, cnt_d;
  logic [mp1g_pkg::IdxW-1:0]   idx_q, idx_d;

  logic                        out_v_q, out_v_d;
  logic [mp1g_pkg::ValW-1:0]   oval_q, oval_d;
  logic [mp1g_pkg::IdxW-1:0]   oidx_q, oidx_d;
  logic                        olast_q, olast_d;

  logic emit, done, load, win_end;

  assign emit    = cur_v_q && (!out_v_q || out_ready_i);
  assign win_end = (cnt_q == cur_q.width - 1'b1);

  // result generation and sequencing
  always_comb begin
    cur_d   = cur_q;
    cur_v_d = cur_v_q;
    ph_d    = ph_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    out_v_d = out_v_q && !out_ready_i;
    oval_d  = oval_q;
    oidx_d  = oidx_q;
    olast_d = olast_q;
    done    = 1'b0;

    if (emit) begin
      out_v_d = 1'b1;
      if (cur_q.kind == mp1g_pkg::KindFwd) begin
        oval_d  = cur_q.value;
        oidx_d  = cur_q.index;
        olast_d = cur_q.last;
        done    = 1'b1;
      end else if (ph_q == PhWin) begin
        oval_d  = (idx_q == cur_q.pos) ? cur_q.value : '0;
        oidx_d  = idx_q;
        olast_d = win_end && cur_q.tail == '0 && cur_q.last;
        done    = win_end && cur_q.tail == '0;
        if (win_end) begin
          ph_d  = PhTail;
          idx_d = cur_q.tail_base;
          cnt_d = '0;
        end else begin
          idx_d = idx_q + 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end else begin
        oval_d  = '0;
        oidx_d  = idx_q;
        done    = (cnt_q == cur_q.tail - 1'b1);
        olast_d = done;
        idx_d   = idx_q + 1'b1;
        cnt_d   = cnt_q + 1'b1;
      end
    end

    // take the next command as the current one finishes, or whenever none is held
    if (load) begin
      cur_v_d = cmd_valid_i;
      cur_d   = cmd_i;
      cnt_d   = '0;
      if (cmd_i.has_win) begin
        ph_d  = PhWin;
        idx_d = cmd_i.index;
      end else begin
        ph_d  = PhTail;
        idx_d = cmd_i.tail_base;
      end
    end
  end

  assign load        = !cur_v_q || (emit && done);
  assign cmd_ready_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      cur_v_q <= 1'b0;
      ph_q    <= PhWin;
      cnt_q   <= '0;
      idx_q   <= '0;
      out_v_q <= 1'b0;
      oval_q  <= '0;
      oidx_q  <= '0;
      olast_q <= 1'b0;
    end else begin
      cur_q   <= cur_d;
      cur_v_q <= cur_v_d;
      ph_q    <= ph_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      out_v_q <= out_v_d;
      oval_q  <= oval_d;
      oidx_q  <= oidx_d;
      olast_q <= olast_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_value_o = oval_q;
  assign out_index_o = oidx_q;
  assign out_last_o  = olast_q;

`ifndef ASSERT_OFF
  a_win_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_v_q && cur_q.kind == mp1g_pkg::KindBwd && ph_q == PhWin
      |-> cur_q.has_win && cnt_q < cur_q.width)
    else $error("window counter out of range");
  a_tail_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_v_q && cur_q.kind == mp1g_pkg::KindBwd && ph_q == PhTail
      |-> cnt_q < cur_q.tail)
    else $error("tail counter out of range");
`endif

endmodule

[verif/mp1g_pool_checker.sv]
// checker for the 1-d max pool: predicts results from input transfers and compares outputs
module mp1g_pool_checker
  import mp1g_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [WidthW-1:0]       cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    func_i,
  input  logic signed [ValW-1:0]  value_i,
  input  logic                    last_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [ValW-1:0]  out_value_i,
  input  logic [IdxW-1:0]         out_index_i,
  input  logic                    out_last_i,
  output int unsigned             results_due_o,
  output int unsigned             errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StoreDepth = 1024;
  localparam int unsigned PrintLimit = 100;

  typedef struct {
    logic signed [ValW-1:0] value;
    logic [IdxW-1:0]        index;
    logic                   last;
  } pool_result_t;

  pool_result_t due_q[$];
  int unsigned  due_count;
  int unsigned  mismatch_count;

  // our own copy of the block state
  logic [WidthW-1:0]      width_reg;
  logic signed [ValW-1:0] peak_val;
  logic [IdxW-1:0]        peak_pos;
  logic [10:0]            sample_pos;
  logic [WidthW-1:0]      win_fill;
  logic [IdxW-1:0]        argmax_mem [StoreDepth];
  logic [10:0]            windows_done;
  logic [WidthW-1:0]      tail_len;
  logic [10:0]            grad_win;

  assign results_due_o = due_count;
  assign errors_o      = mismatch_count;

  // zero acts as one, anything above the widest window is clamped
  function automatic int unsigned window_size(logic [WidthW-1:0] w);
    if (w == '0) return 1;
    if (w > MaxWidth) return MaxWidth;
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < PrintLimit) $display("%0t ns mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic queue_result(logic signed [ValW-1:0] v, int unsigned idx, logic lst);
    pool_result_t r;
    r.value = v;
    r.index = IdxW'(idx);
    r.last  = lst;
    due_q.push_back(r);
  endtask

  // forward sample: running max per window, first maximum wins ties
  task automatic pool_sample(logic signed [ValW-1:0] v, logic lst);
    int unsigned w;
    w = window_size(width_reg);
    // a sample at position zero starts a new vector
    if (sample_pos == '0 && win_fill == '0) begin
      windows_done = '0;
      grad_win     = '0;
    end
    // samples past the end of the store are dropped
    if (sample_pos < StoreDepth) begin
      if (win_fill == '0 || v > peak_val) begin
        peak_val = v;
        peak_pos = sample_pos[IdxW-1:0];
      end
      win_fill++;
      sample_pos++;
      if (win_fill >= w) begin
        queue_result(peak_val, peak_pos, lst);
        if (windows_done < StoreDepth) argmax_mem[windows_done[IdxW-1:0]] = peak_pos;
        windows_done++;
        win_fill = '0;
      end
    end
    // end of vector keeps the partial window size for the backward tail
    if (lst) begin
      tail_len   = win_fill;
      sample_pos = '0;
      win_fill   = '0;
    end
  endtask

  // backward gradient: route to the stored argmax, zeros elsewhere
  task automatic route_gradient(logic signed [ValW-1:0] g, logic lst);
    int unsigned     w;
    int unsigned     base;
    int unsigned     n;
    logic [IdxW-1:0] pos;
    logic [IdxW-1:0] idx;
    pool_result_t    tail_res;
    w = window_size(width_reg);
    n = 0;
    if (grad_win < windows_done && grad_win < StoreDepth) begin
      pos  = argmax_mem[grad_win[IdxW-1:0]];
      base = grad_win * w;
      for (int unsigned k = 0; k < w; k++) begin
        idx = IdxW'(base + k);
        queue_result((idx == pos) ? g : '0, idx, 1'b0);
        n++;
      end
      grad_win++;
    end
    // zeros for the dropped partial window, final result of the run marked
    if (lst) begin
      base = windows_done * w;
      for (int unsigned k = 0; k < tail_len && k < MaxWidth; k++) begin
        queue_result('0, base + k, 1'b0);
        n++;
      end
      if (n > 0) begin
        tail_res = due_q.pop_back();
        tail_res.last = 1'b1;
        due_q.push_back(tail_res);
      end
      grad_win = '0;
    end
  endtask

  task automatic check_result();
    pool_result_t want;
    if (due_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result value %h index %0d last %b",
                                out_value_i, out_index_i, out_last_i));
      return;
    end
    want = due_q.pop_front();
    if (out_value_i !== want.value)
      report_mismatch($sformatf("out_value %h, want %h (index %0d)",
                                out_value_i, want.value, want.index));
    if (out_index_i !== want.index)
      report_mismatch($sformatf("out_index %0d, want %0d", out_index_i, want.index));
    if (out_last_i !== want.last)
      report_mismatch($sformatf("out_last %b, want %b (index %0d)",
                                out_last_i, want.last, want.index));
  endtask

  // track config, predict on input transfer, compare on output transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_q.delete();
      width_reg    = WidthW'(2);
      peak_val     = '0;
      peak_pos     = '0;
      sample_pos   = '0;
      win_fill     = '0;
      windows_done = '0;
      tail_len     = '0;
      grad_win     = '0;
    end else begin
      if (cfg_we_i) width_reg = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        if (item_kind_e'(func_i) == KindFwd) pool_sample(value_i, last_i);
        else route_gradient(value_i, last_i);
      end
      if (out_valid_i && out_ready_i) check_result();
    end
    due_count = due_q.size();
  end

endmodule

[verif/tb.sv]
// testbench top for the 1-d max pool: clock, reset, stimulus, watchdog and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mp1g_pkg::*;

  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned HoldCycles = 300;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [WidthW-1:0]      cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic                   func_i      = 1'b0;
  logic signed [ValW-1:0] value_i     = '0;
  logic                   last_i      = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic signed [ValW-1:0] out_value_o;
  logic [IdxW-1:0]        out_index_o;
  logic                   out_last_o;

  int unsigned results_due;
  int unsigned mismatches;

  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_stall_pct = 0;
  bit                long_hold      = 1'b0;
  logic [WidthW-1:0] cur_width      = WidthW'(2);
  int unsigned       quiet_cycles   = 0;

  max_pool_1d_with_gradient_route i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .value_i     (value_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_value_o (out_value_o),
    .out_index_o (out_index_o),
    .out_last_o  (out_last_o)
  );

  mp1g_pool_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .func_i        (func_i),
    .value_i       (value_i),
    .last_i        (last_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_value_i   (out_value_o),
    .out_index_i   (out_index_o),
    .out_last_i    (out_last_o),
    .results_due_o (results_due),
    .errors_o      (mismatches)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog: too long without any transfer ends the run
  always @(posedge clk_i) begin
    if (rst_ni && !((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      quiet_cycles <= 0;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        long_hold = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // half wide spread, with narrow values for ties and the signed extremes
  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(3))
      0:       return ValW'($urandom_range(0, 4)) - ValW'(2);
      1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // one transfer on the input channel, called and returning at a falling edge
  task automatic send(item_kind_e kind, logic [ValW-1:0] v, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= kind;
    value_i    <= v;
    last_i     <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drain everything, then give items without results time to leave the pipe
  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (results_due != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_width(logic [WidthW-1:0] w);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    cur_width    = w;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // vectors of random length, most followed by a backward pass, with some broken ones
  task automatic random_traffic(int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned wins;
    int unsigned grads;
    int unsigned w;
    int unsigned r;
    bit          drop_last;
    w = (cur_width == '0) ? 1 : ((cur_width > MaxWidth) ? MaxWidth : cur_width);
    // gradients against the previous pass, possibly stored under another width
    grads = $urandom_range(0, 3);
    for (int unsigned i = 0; i < grads; i++) send(KindBwd, pick_value(), i == grads - 1);
    sent = grads;
    while (sent < n_items) begin
      len       = $urandom_range(1, (w < 3) ? 9 : 4 * w - 1);
      drop_last = ($urandom_range(19) == 0);
      for (int unsigned i = 0; i < len; i++)
        send(KindFwd, pick_value(), !drop_last && i == len - 1);
      wins = len / w;
      r    = $urandom_range(9);
      if (r < 7) grads = (wins == 0) ? 1 : wins;
      else if (r == 7) grads = wins + $urandom_range(1, 2);
      else if (r == 8) grads = $urandom_range(0, wins);
      else grads = 0;
      for (int unsigned i = 0; i < grads; i++)
        send(KindBwd, pick_value(), r != 8 && i == grads - 1);
      sent += len + grads;
    end
  endtask

  task automatic run_phase(logic [WidthW-1:0] w, int unsigned idle, int unsigned stall,
                           int unsigned n_items, bit hold);
    set_width(w);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    // receiver holds off while samples keep coming, so the input backs up
    if (hold) begin
      long_hold = 1'b1;
      for (int unsigned i = 0; i < 24; i++) send(KindFwd, pick_value(), 1'b0);
    end
    random_traffic(n_items);
    settle();
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, reset width of two
    send(KindBwd, 32'h1234_5678, 1'b1);  // gradient before any vector
    send(KindFwd, 32'h7FFF_FFFF, 1'b0);
    send(KindFwd, 32'h8000_0000, 1'b0);
    send(KindFwd, 32'hFFFF_FFFB, 1'b0);  // equal values, first one wins
    send(KindFwd, 32'hFFFF_FFFB, 1'b0);
    send(KindFwd, 32'h8000_0000, 1'b0);
    send(KindFwd, 32'h8000_0000, 1'b1);  // window closes on the last sample
    send(KindBwd, 32'hFFFF_FFFF, 1'b0);
    send(KindBwd, 32'h0000_0001, 1'b0);
    send(KindBwd, 32'h8000_0000, 1'b0);
    send(KindBwd, 32'h7FFF_FFFF, 1'b0);  // gradient beyond the windows
    send(KindBwd, 32'h5555_5555, 1'b1);  // last with nothing to emit
    send(KindFwd, 32'h0000_0003, 1'b0);
    send(KindFwd, 32'h0000_0009, 1'b0);
    send(KindFwd, 32'h0000_0001, 1'b1);  // vector ends in a partial window
    send(KindBwd, 32'hAAAA_AAAA, 1'b1);  // window plus one tail zero
    send(KindBwd, 32'h0000_0000, 1'b1);  // first window again, plus one tail zero
    settle();

    // random phases over the width settings and idling patterns
    run_phase(WidthW'(1), 0, 0, 50, 1'b0);
    run_phase(WidthW'(16), 60, 0, 60, 1'b0);
    run_phase(WidthW'(0), 0, 60, 40, 1'b1);
    run_phase(WidthW'(31), 34, 34, 50, 1'b0);
    run_phase(WidthW'(17), 34, 34, 30, 1'b0);
    run_phase(WidthW'($urandom_range(2, 15)), 0, 60, 40, 1'b0);
    run_phase(WidthW'($urandom_range(2, 15)), 60, 0, 30, 1'b0);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/mp1g_pkg.sv
hw/rtl/mp1g_ram.sv
hw/rtl/mp1g_fifo.sv
hw/rtl/mp1g_front.sv
hw/rtl/mp1g_back.sv
hw/rtl/max_pool_1d_with_gradient_route.sv
verif/mp1g_pool_checker.sv
verif/tb.sv
